FILE: hdl/integer_to_radix_digits_top_defines.svh
// ----------------------------------------------------------------------------
// Integer to radix digits - assertion macros
// Shared property macros for the checker; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH

// same-cycle implication
`define ITRD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itrd: same-cycle check failed");

// next-cycle implication
`define ITRD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itrd: next-cycle check failed");

`endif

FILE: hdl/itrd_pkg.sv
// ----------------------------------------------------------------------------
// Integer to radix digits - package
// Constants, register indexes, sequencer states and the digit table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package itrd_pkg;

	localparam int unsigned MAX_SYMBOLS_DEF = 16;
	localparam int unsigned TABLE_SIZE      = 16;
	localparam int unsigned MIN_SYMBOLS     = 2;
	localparam int unsigned MAX_DIGITS      = 32;
	localparam int unsigned DIV_STEPS       = 8;
	localparam int unsigned DIV_CYCLES      = MAX_DIGITS / DIV_STEPS;

	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_NONE  = 8'h00;

	typedef enum logic [1:0] {
		REG_DIGITS_LOW   = 2'd0,
		REG_DIGITS_HIGH  = 2'd1,
		REG_SYMBOL_COUNT = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_SIGN,
		ST_EMIT
	} st_t;

	function automatic logic [7:0] table_symbol(
		input logic [63:0] lo,
		input logic [63:0] hi,
		input logic [3:0]  k
	);
		logic [63:0] word;
		word = k[3] ? hi : lo;
		return word[{k[2:0], 3'b000} +: 8];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/integer_to_radix_digits_top.sv
// ----------------------------------------------------------------------------
// Integer to radix digits - top level
// Converts a signed 32-bit integer into digit symbols of a configured radix.
// ----------------------------------------------------------------------------
// Usage:
//   Load digits_low, digits_high and symbol_count through wr_en/wr_index/
//   wr_data while busy is low. A beat is taken when start is high and busy
//   is low. Results leave one per cycle on symbol/last/table_invalid, marked
//   by strobe, most significant digit first, a '-' beat leading for negative
//   values; last marks the final beat. A bad table gives a single beat with
//   table_invalid and last set and symbol zero.
// Sequencing (r = symbol_count):
//   the table check visits the r symbols in turn and stops at the first fault,
//   then the shared divider (8 quotient bits a cycle) yields the digits least
//   significant first, then the beats go out; the first result is registered
//   from the sign or emit state, or from the check state on a bad table. busy
//   stays high until the last beat is registered.
// Reset clears the table registers and the sequencer. Results cannot be
// held off: each beat is present for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_digits_top
	import itrd_pkg::*;
#(
	parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] value,
	input  wire logic               wr_en,
	input  wire logic [1:0]         wr_index,
	input  wire logic [63:0]        wr_data,
	output logic                    strobe,
	output logic [7:0]              symbol,
	output logic                    last,
	output logic                    table_invalid
);

	localparam int unsigned STEP_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
	localparam int unsigned ND_W   = $clog2(MAX_DIGITS + 1);
	localparam int unsigned BUF_W  = $clog2(MAX_DIGITS);

	st_t state_q, state_d;

	logic [63:0]       digits_low_q, digits_high_q;
	logic [4:0]        symbol_count_q;
	logic              neg_q;
	logic [31:0]       mag_q;
	logic [3:0]        rem_q;
	logic [STEP_W-1:0] step_q;
	logic [3:0]        idx_q;
	logic [ND_W-1:0]   nd_q;
	logic [3:0]        buf_q [MAX_DIGITS];

	logic              strobe_q, last_q, invalid_q;
	logic [7:0]        symbol_q;

	logic        count_bad, sym_bad, dup, chk_bad, chk_done;
	logic [7:0]  sym_i;
	logic [4:0]  div_t;
	logic [3:0]  div_rem;
	logic [31:0] div_quo;
	logic        div_last, div_more;
	logic [3:0]  emit_digit;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_low_q   <= '0;
			digits_high_q  <= '0;
			symbol_count_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DIGITS_LOW:   digits_low_q   <= wr_data;
				REG_DIGITS_HIGH:  digits_high_q  <= wr_data;
				REG_SYMBOL_COUNT: symbol_count_q <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	// table check, one symbol per cycle against all later ones
	always_comb begin
		count_bad = (symbol_count_q < 5'(MIN_SYMBOLS)) ||
			(symbol_count_q > 5'(MAX_SYMBOLS));
		sym_i   = table_symbol(digits_low_q, digits_high_q, idx_q);
		sym_bad = (sym_i == SYM_NONE) || (sym_i == SYM_PLUS) || (sym_i == SYM_MINUS);
		dup     = 1'b0;
		for (int j = 0; j < TABLE_SIZE; j++) begin
			if ((j < MAX_SYMBOLS) && (5'(j) > {1'b0, idx_q}) &&
					(5'(j) < symbol_count_q) &&
					(table_symbol(digits_low_q, digits_high_q, 4'(j)) == sym_i))
				dup = 1'b1;
		end
		chk_bad  = count_bad || sym_bad || dup;
		chk_done = ({1'b0, idx_q} == (symbol_count_q - 5'd1));
	end

	// shared restoring divider, DIV_STEPS quotient bits a cycle
	always_comb begin
		div_rem = rem_q;
		div_quo = mag_q;
		div_t   = '0;
		for (int k = 0; k < DIV_STEPS; k++) begin
			div_t = {div_rem, div_quo[31]};
			if (div_t >= symbol_count_q) begin
				div_rem = 4'(div_t - symbol_count_q);
				div_quo = {div_quo[30:0], 1'b1};
			end else begin
				div_rem = div_t[3:0];
				div_quo = {div_quo[30:0], 1'b0};
			end
		end
		div_last = (step_q == STEP_W'(DIV_CYCLES - 1));
		div_more = (div_quo != '0) && (nd_q < ND_W'(MAX_DIGITS - 1));
	end

	assign emit_digit = buf_q[BUF_W'(nd_q - ND_W'(1))];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (chk_bad)
					state_d = ST_IDLE;
				else if (chk_done)
					state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_last && !div_more)
					state_d = neg_q ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (nd_q == ND_W'(1))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				neg_q  <= value[31];
				mag_q  <= value[31] ? (32'd0 - 32'(value)) : 32'(value);
				rem_q  <= '0;
				step_q <= '0;
				idx_q  <= '0;
				nd_q   <= '0;
			end
			ST_CHECK: idx_q <= idx_q + 4'd1;
			ST_DIVIDE: begin
				mag_q  <= div_quo;
				rem_q  <= div_last ? 4'd0 : div_rem;
				step_q <= step_q + STEP_W'(1);
				if (div_last) begin
					buf_q[BUF_W'(nd_q)] <= div_rem;
					nd_q <= nd_q + ND_W'(1);
				end
			end
			ST_EMIT: nd_q <= nd_q - ND_W'(1);
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ((state_q == ST_CHECK) && chk_bad) ||
				(state_q == ST_SIGN) || (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			symbol_q  <= SYM_NONE;
			last_q    <= 1'b1;
			invalid_q <= 1'b1;
		end else if (state_q == ST_SIGN) begin
			symbol_q  <= SYM_MINUS;
			last_q    <= 1'b0;
			invalid_q <= 1'b0;
		end else begin
			symbol_q  <= table_symbol(digits_low_q, digits_high_q, emit_digit);
			last_q    <= (nd_q == ND_W'(1));
			invalid_q <= 1'b0;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign strobe        = strobe_q;
	assign symbol        = symbol_q;
	assign last          = last_q;
	assign table_invalid = invalid_q;

endmodule

`default_nettype wire

FILE: hdl/itrd_checker.sv
// ----------------------------------------------------------------------------
// Integer to radix digits - port checker
// Watches the top level's ports for result framing and busy behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_radix_digits_top_defines.svh"

module itrd_checker
	import itrd_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       strobe,
	input wire logic [7:0] symbol,
	input wire logic       last,
	input wire logic       table_invalid
);

	`ITRD_ASSERT_NOW(a_invalid_beat, strobe && table_invalid, last && (symbol == SYM_NONE))
	`ITRD_ASSERT_NEXT(a_beats_contiguous, strobe && !last, strobe)
	`ITRD_ASSERT_NOW(a_last_frees, strobe && last, !busy)
	`ITRD_ASSERT_NOW(a_sign_leads, strobe && !table_invalid && (symbol == SYM_MINUS), !last)
	`ITRD_ASSERT_NEXT(a_start_busy, start && !busy, busy)

endmodule

bind integer_to_radix_digits_top itrd_checker u_itrd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.strobe        (strobe),
	.symbol        (symbol),
	.last          (last),
	.table_invalid (table_invalid)
);

`default_nettype wire

FILE: dv/integer_to_radix_digits_checker.sv
// ----------------------------------------------------------------------------
// Integer to radix digits - checker
// Tracks register writes, predicts the symbol beats of every accepted value
// and compares each result beat field by field against the oldest one due.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_checker
	import itrd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic signed [31:0] value,
	input  wire logic               wr_en,
	input  wire logic [1:0]         wr_index,
	input  wire logic [63:0]        wr_data,
	input  wire logic               strobe,
	input  wire logic [7:0]         symbol,
	input  wire logic               last,
	input  wire logic               table_invalid,
	output int unsigned             outstanding,
	output int unsigned             mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
		logic       table_invalid;
	} digit_beat_t;

	logic [63:0]  tbl_lo;
	logic [63:0]  tbl_hi;
	logic [4:0]   tbl_count;
	digit_beat_t  beats_due[$];
	digit_beat_t  due;
	int unsigned  beat_no;

	function automatic digit_beat_t make_beat(input logic [7:0] s, input logic l,
			input logic bad);
		digit_beat_t b;
		b.symbol        = s;
		b.last          = l;
		b.table_invalid = bad;
		return b;
	endfunction

	function automatic logic [7:0] tbl_sym(input int unsigned k);
		logic [63:0] word;
		word = (k < 8) ? tbl_lo : tbl_hi;
		return word[8 * (k % 8) +: 8];
	endfunction

	function automatic bit table_valid();
		if (tbl_count < MIN_SYMBOLS || tbl_count > MAX_SYMBOLS_DEF)
			return 1'b0;
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_sym(i) == SYM_NONE || tbl_sym(i) == SYM_PLUS || tbl_sym(i) == SYM_MINUS)
				return 1'b0;
			for (int j = i + 1; j < tbl_count; j++)
				if (tbl_sym(j) == tbl_sym(i))
					return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic predict_digits(input logic [31:0] raw);
		logic [31:0] mag;
		logic [7:0]  digs [MAX_DIGITS];
		int          nd;
		logic        neg;
		if (!table_valid()) begin
			beats_due.push_back(make_beat(SYM_NONE, 1'b1, 1'b1));
			return;
		end
		neg = raw[31];
		mag = neg ? -raw : raw;
		nd = 0;
		do begin
			digs[nd] = tbl_sym(mag % tbl_count);
			mag = mag / tbl_count;
			nd++;
		end while (mag != 0 && nd < MAX_DIGITS);
		if (neg)
			beats_due.push_back(make_beat(SYM_MINUS, 1'b0, 1'b0));
		while (nd > 0) begin
			nd--;
			beats_due.push_back(make_beat(digs[nd], nd == 0, 1'b0));
		end
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t itrd beat %0d: %s", $time, beat_no, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_lo      = '0;
			tbl_hi      = '0;
			tbl_count   = '0;
			beat_no     = 0;
			mismatches  = 0;
			beats_due.delete();
			outstanding <= 0;
		end else begin
			if (strobe) begin
				if (beats_due.size() == 0) begin
					report_mismatch($sformatf("unexpected beat symbol %02h last %0b invalid %0b",
						symbol, last, table_invalid));
				end else begin
					due = beats_due.pop_front();
					if (symbol !== due.symbol)
						report_mismatch($sformatf("symbol %02h, expected %02h",
							symbol, due.symbol));
					if (last !== due.last)
						report_mismatch($sformatf("last %0b, expected %0b", last, due.last));
					if (table_invalid !== due.table_invalid)
						report_mismatch($sformatf("table_invalid %0b, expected %0b",
							table_invalid, due.table_invalid));
				end
				beat_no++;
			end
			if (start && !busy)
				predict_digits(value);
			if (wr_en) begin
				case (reg_idx_t'(wr_index))
					REG_DIGITS_LOW:   tbl_lo = wr_data;
					REG_DIGITS_HIGH:  tbl_hi = wr_data;
					REG_SYMBOL_COUNT: tbl_count = wr_data[4:0];
					default: ;
				endcase
			end
			outstanding <= beats_due.size();
		end
	end

endmodule

FILE: dv/integer_to_radix_digits_top_test.sv
// ----------------------------------------------------------------------------
// Integer to radix digits - testbench top
// Loads directed and random digit tables, valid and broken, and feeds values
// with random gaps; the checker predicts and compares every symbol beat.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import itrd_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 390;

	typedef enum int {
		FLT_PLUS,
		FLT_MINUS,
		FLT_ZERO,
		FLT_REPEAT,
		FLT_COUNT
	} table_fault_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               start    = 1'b0;
	logic signed [31:0] value    = '0;
	logic               wr_en    = 1'b0;
	logic [1:0]         wr_index = '0;
	logic [63:0]        wr_data  = '0;
	wire                busy;
	wire                strobe;
	wire  [7:0]         symbol;
	wire                last;
	wire                table_invalid;
	int unsigned        outstanding;
	int unsigned        mismatches;

	logic [7:0]  sym_bytes [16];
	bit          burst;
	int unsigned random_done;

	always #6 clk = ~clk;

	integer_to_radix_digits_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.strobe        (strobe),
		.symbol        (symbol),
		.last          (last),
		.table_invalid (table_invalid)
	);

	integer_to_radix_digits_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.strobe        (strobe),
		.symbol        (symbol),
		.last          (last),
		.table_invalid (table_invalid),
		.outstanding   (outstanding),
		.mismatches    (mismatches)
	);

	function automatic int unsigned idle_len();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return 0;
			5, 6, 7:       return $urandom_range(1, 3);
			8:             return $urandom_range(4, 12);
			default:       return $urandom_range(20, 60);
		endcase
	endfunction

	function automatic logic [31:0] pick_value(input int unsigned r);
		logic [63:0] p;
		logic [31:0] v;
		int unsigned k;
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4, 5:       return $urandom_range(600) - 300;
			6: begin
				case ($urandom_range(5))
					0:       return 32'h0000_0000;
					1:       return 32'h0000_0001;
					2:       return 32'hFFFF_FFFF;
					3:       return 32'h8000_0000;
					4:       return 32'h7FFF_FFFF;
					default: return 32'h8000_0001;
				endcase
			end
			default: begin
				if (r < 2)
					r = 2;
				p = 1;
				k = $urandom_range(31);
				while (k != 0 && p * r <= 64'h8000_0000) begin
					p = p * r;
					k--;
				end
				v = p[31:0] + ($urandom_range(2) - 1);
				if ($urandom_range(1))
					v = -v;
				return v;
			end
		endcase
	endfunction

	function automatic int unsigned pick_radix();
		case ($urandom_range(4))
			0:       return 2;
			1:       return 16;
			default: return $urandom_range(3, 15);
		endcase
	endfunction

	task automatic text_table();
		for (int i = 0; i < 16; i++)
			sym_bytes[i] = (i < 10) ? 8'(8'h30 + i) : 8'(8'h41 + i - 10);
	endtask

	// distinct usable symbols below r, anything at all above
	task automatic fill_valid(input int unsigned r);
		bit         taken [256];
		logic [7:0] b;
		foreach (taken[i])
			taken[i] = 1'b0;
		taken[SYM_NONE]  = 1'b1;
		taken[SYM_PLUS]  = 1'b1;
		taken[SYM_MINUS] = 1'b1;
		for (int i = 0; i < 16; i++) begin
			if (i < r) begin
				do b = 8'($urandom_range(255)); while (taken[b]);
				taken[b] = 1'b1;
				sym_bytes[i] = b;
			end else begin
				sym_bytes[i] = 8'($urandom_range(255));
			end
		end
	endtask

	task automatic spoil_table(input table_fault_t f, inout int unsigned r);
		int unsigned pos;
		int unsigned other;
		pos   = $urandom_range(r - 1);
		other = (pos + 1 + $urandom_range(r - 2)) % r;
		case (f)
			FLT_PLUS:   sym_bytes[pos] = SYM_PLUS;
			FLT_MINUS:  sym_bytes[pos] = SYM_MINUS;
			FLT_ZERO:   sym_bytes[pos] = SYM_NONE;
			FLT_REPEAT: sym_bytes[pos] = sym_bytes[other];
			default:    r = $urandom_range(1) ? $urandom_range(1) : $urandom_range(17, 31);
		endcase
	endtask

	task automatic commit_table(input int unsigned count);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] cw;
		for (int i = 0; i < 8; i++) begin
			lo[8 * i +: 8] = sym_bytes[i];
			hi[8 * i +: 8] = sym_bytes[i + 8];
		end
		cw      = {$urandom, $urandom};
		cw[4:0] = count[4:0];
		wr_en    <= 1'b1;
		wr_index <= REG_DIGITS_LOW;
		wr_data  <= lo;
		@(posedge clk);
		wr_index <= REG_DIGITS_HIGH;
		wr_data  <= hi;
		@(posedge clk);
		wr_index <= REG_SYMBOL_COUNT;
		wr_data  <= cw;
		@(posedge clk);
		wr_en    <= 1'b0;
	endtask

	task automatic convert(input logic [31:0] v);
		int unsigned gap;
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		gap = burst ? 0 : idle_len();
		if (gap != 0) begin
			start <= 1'b0;
			value <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned r;
		int unsigned n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table straight out of reset
		convert(32'h0000_0000);
		convert(32'h8000_0000);
		drain();

		text_table();
		commit_table(10);
		convert(32'd0);
		convert(32'd1);
		convert(-32'sd1);
		convert(32'd9);
		convert(32'd10);
		convert(-32'sd10);
		convert(32'h7FFF_FFFF);
		convert(32'h8000_0000);
		convert(32'd1234567);
		convert(-32'sd987654);
		drain();

		commit_table(16);
		convert(32'h8000_0000);
		convert(32'd255);
		convert(-32'sd16);
		drain();

		// binary, sign character parked just past the last symbol in use
		sym_bytes[2] = SYM_MINUS;
		commit_table(2);
		convert(32'd0);
		convert(32'h8000_0000);
		convert(32'h7FFF_FFFF);
		convert(32'hFFFF_FFFF);
		drain();

		text_table();
		sym_bytes[9] = SYM_PLUS;
		commit_table(10);
		convert(32'd42);
		drain();

		text_table();
		sym_bytes[0] = SYM_MINUS;
		commit_table(16);
		convert(-32'sd42);
		drain();

		text_table();
		sym_bytes[5] = SYM_NONE;
		commit_table(8);
		convert(32'd7);
		drain();

		text_table();
		sym_bytes[12] = sym_bytes[3];
		commit_table(16);
		convert(32'd100);
		drain();

		text_table();
		commit_table(17);
		convert(32'd1);
		drain();

		commit_table(1);
		convert(32'd0);
		drain();

		random_done = 0;
		while (random_done < RANDOM_ITEMS) begin
			burst = ($urandom_range(4) == 0);
			r = pick_radix();
			fill_valid(r);
			if ($urandom_range(4) == 0) begin
				spoil_table(table_fault_t'($urandom_range(FLT_COUNT)), r);
				n = $urandom_range(3, 8);
			end else begin
				n = $urandom_range(15, 40);
			end
			commit_table(r);
			repeat (n)
				convert(pick_value(r));
			random_done += n;
			drain();
		end

		if (mismatches == 0)
			$display("[integer_to_radix_digits_top] OK");
		else
			$display("[integer_to_radix_digits_top] ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[integer_to_radix_digits_top] ERROR");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/itrd_pkg.sv
hdl/integer_to_radix_digits_top.sv
hdl/itrd_checker.sv
dv/integer_to_radix_digits_checker.sv
dv/integer_to_radix_digits_top_test.sv
